>>> rtl/sbpp_pkg.sv
// ----------------------------------------------------------------------------
// sbpp_pkg
// Shared types, sizes and helpers for the byte-position parity generator.
// ----------------------------------------------------------------------------
package sbpp_pkg;

  // number of position bits tracked, one accumulator cell per bit
  localparam int MAX_ADDR_BITS = 16;
  // one extra cell at the end of the row holds the total xor
  localparam int NUM_CELLS     = MAX_ADDR_BITS + 1;
  // width of a parity index counter, holds 0 .. MAX_ADDR_BITS
  localparam int CNT_W         = $clog2(NUM_CELLS);

  // input item
  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [7:0] parity_byte;
    logic [4:0] parity_index;
    logic       run_last;
    logic       overflow;
  } out_item_t;

  // control shared by every cell in the row
  typedef struct packed {
    logic       step;        // an input item is taken this cycle
    logic       clear;       // item is the final byte, accumulators restart
    logic       load;        // snapshot the row into the drain chain
    logic       shift;       // drain chain moves one cell toward the output
    logic [7:0] data_byte;   // byte of the current item
    logic [7:0] total_snap;  // total xor including the current byte
  } cell_ctrl_t;

  // bit length of a position value, zero for position zero
  function automatic logic [CNT_W-1:0] bit_length(input logic [MAX_ADDR_BITS-1:0] pos);
    logic [CNT_W-1:0] k;
    k = '0;
    for (int i = 0; i < MAX_ADDR_BITS; i++) begin
      if (pos[i]) begin
        k = CNT_W'(i + 1);
      end
    end
    return k;
  endfunction

endpackage

>>> rtl/sbpp_cell.sv
// ----------------------------------------------------------------------------
// sbpp_cell
// One parity cell: an 8-bit xor accumulator plus one stage of the drain chain.
// ----------------------------------------------------------------------------
module sbpp_cell (
  input  logic                clk,
  input  logic                rst,
  input  sbpp_pkg::cell_ctrl_t ctrl,
  input  logic                hit,
  input  logic                pick_total,
  input  logic [7:0]          shift_in,
  output logic [7:0]          shift_out,
  output logic [7:0]          snap
);
  import sbpp_pkg::*;

  logic [7:0] acc;
  logic [7:0] drain;

  // accumulator value with the current byte folded in
  assign snap = acc ^ (hit ? ctrl.data_byte : 8'h00);

  // accumulator, restarts after the final byte of a message
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= 8'h00;
    end else if (ctrl.step) begin
      acc <= ctrl.clear ? 8'h00 : snap;
    end
  end

  // drain stage, loaded from the row and shifted toward cell zero
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      drain <= pick_total ? ctrl.total_snap : snap;
    end else if (ctrl.shift) begin
      drain <= shift_in;
    end
  end

  assign shift_out = drain;

endmodule

>>> rtl/secded_byte_position_parity.sv
// ----------------------------------------------------------------------------
// secded_byte_position_parity
// Byte-position parity generator over a byte stream, one byte per item.
// ----------------------------------------------------------------------------
// Takes one message byte per cycle; every position bit has its own cell that
// xors in the bytes whose position has that bit set, and a last cell keeps the
// xor of all bytes. On the final byte the whole row is copied into a drain
// chain in the same cycle and the accumulators restart, so the next message
// streams in without a gap while the K+1 parity bytes leave one per cycle
// unless the output stalls, index zero first. A final byte is held off only
// while the previous run is still draining, that is until the last parity
// byte of that run is taken.
// Messages longer than 2^MAX_ADDR_BITS bytes wrap the position and report
// overflow on all MAX_ADDR_BITS+1 results of their run.
// ----------------------------------------------------------------------------
module secded_byte_position_parity (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  sbpp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output sbpp_pkg::out_item_t out_data
);
  import sbpp_pkg::*;

  logic [MAX_ADDR_BITS-1:0] pos;
  logic                     ovf_flag;
  logic                     busy;
  logic [CNT_W-1:0]         idx;
  logic [CNT_W-1:0]         run_k;
  logic                     run_ovf;

  logic                     in_acc;
  logic                     out_acc;
  logic                     drain_done;
  logic                     chain_free;
  logic [CNT_W-1:0]         k_now;
  cell_ctrl_t               ctrl;
  logic [7:0]               chain [0:NUM_CELLS];
  logic [7:0]               snaps [0:NUM_CELLS-1];

  // handshake
  assign out_acc    = busy && !out_stall;
  assign drain_done = out_acc && (idx == run_k);
  assign chain_free = !busy || drain_done;
  assign in_stall   = in_data.final_byte && !chain_free;
  assign in_acc     = in_valid && !in_stall;

  // number of address parity bytes for the message ending now
  assign k_now = ovf_flag ? CNT_W'(MAX_ADDR_BITS) : bit_length(pos);

  // row control
  always_comb begin
    ctrl.step       = in_acc;
    ctrl.clear      = in_data.final_byte;
    ctrl.load       = in_acc && in_data.final_byte;
    ctrl.shift      = out_acc;
    ctrl.data_byte  = in_data.data_byte;
    ctrl.total_snap = snaps[NUM_CELLS-1];
  end

  // row of cells, the last one accumulates every byte
  assign chain[NUM_CELLS] = 8'h00;
  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    logic hit;
    if (i < MAX_ADDR_BITS) begin : g_bit
      assign hit = pos[i];
    end else begin : g_tot
      assign hit = 1'b1;
    end
    sbpp_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .hit        (hit),
      .pick_total (CNT_W'(i) >= k_now),
      .shift_in   (chain[i+1]),
      .shift_out  (chain[i]),
      .snap       (snaps[i])
    );
  end

  // position counter and overflow flag
  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      ovf_flag <= 1'b0;
    end else if (in_acc) begin
      if (in_data.final_byte) begin
        pos      <= '0;
        ovf_flag <= 1'b0;
      end else begin
        pos <= pos + 1'b1;
        if (&pos) begin
          ovf_flag <= 1'b1;
        end
      end
    end
  end

  // drain control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      idx     <= '0;
      run_k   <= '0;
      run_ovf <= 1'b0;
    end else if (ctrl.load) begin
      busy    <= 1'b1;
      idx     <= '0;
      run_k   <= k_now;
      run_ovf <= ovf_flag;
    end else if (out_acc) begin
      idx <= idx + 1'b1;
      if (drain_done) begin
        busy <= 1'b0;
      end
    end
  end

  // result item
  assign out_valid             = busy;
  assign out_data.parity_byte  = chain[0];
  assign out_data.parity_index = 5'(idx);
  assign out_data.run_last     = (idx == run_k);
  assign out_data.overflow     = run_ovf;

`ifndef ASSERT_OFF
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    in_acc && in_data.final_byte |=> out_valid)
    else $error("run not presented after final byte");
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    out_acc && !out_data.run_last |=> out_valid)
    else $error("run ended before its last result");
  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    out_acc && out_data.run_last && !(in_acc && in_data.final_byte) |=> !out_valid)
    else $error("results continue after last of run");
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> idx <= run_k)
    else $error("parity index past end of run");
  a_no_early_load: assert property (@(posedge clk) disable iff (rst)
    busy && !drain_done && in_valid && in_data.final_byte |-> in_stall)
    else $error("final byte taken while drain chain busy");
`endif

endmodule
